// File: hw/rtl/jcfu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jcfu_pkg;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_SWAIT,
        PH_SBS,
        PH_HEX2,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        HM_LEAD,
        HM_SIGN,
        HM_ZERO,
        HM_X,
        HM_DIG
    } hex_mode_t;

    localparam logic [1:0] ST_CLOSED    = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_OPEN      = 2'd2;

    localparam logic [3:0] KEY_LEN = 4'd11;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;

    localparam int MAX_RES    = 5;
    localparam int BUF_CNT_W  = $clog2(MAX_RES + 1);
    localparam int FIFO_DEPTH = 4;

    localparam logic [31:0] CP_1B_MAX  = 32'h0000_007F;
    localparam logic [31:0] CP_2B_MAX  = 32'h0000_07FF;
    localparam logic [31:0] CP_3B_MAX  = 32'h0000_FFFF;
    localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
    localparam logic [31:0] SUR_HI_MIN = 32'h0000_D800;
    localparam logic [31:0] SUR_HI_MAX = 32'h0000_DBFF;
    localparam logic [31:0] SUR_LO_MIN = 32'h0000_DC00;
    localparam logic [31:0] CP_PLANE1  = 32'h0001_0000;
    localparam logic [5:0]  SUR_HI_TAG = 6'b110110;

    // One word of work handed from the front to the back.
    typedef struct packed {
        logic        cp_valid;
        logic [31:0] cp;
        logic        lit_valid;
        logic [7:0]  lit;
        logic        stat_valid;
        logic [1:0]  stat;
    } rec_t;

    function automatic logic [7:0] key_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h22;
            4'd1:    b = 8'h63;
            4'd2:    b = 8'h6F;
            4'd3:    b = 8'h6E;
            4'd4:    b = 8'h74;
            4'd5:    b = 8'h65;
            4'd6:    b = 8'h6E;
            4'd7:    b = 8'h74;
            4'd8:    b = 8'h22;
            4'd9:    b = 8'h3A;
            4'd10:   b = 8'h22;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] key_fallback(input logic [3:0] len);
        return (len == 4'd9) ? 4'd1 : 4'd0;
    endfunction

    function automatic logic [3:0] kmp_step(input logic [3:0] len, input logic [7:0] c);
        logic [3:0] l;
        l = len;
        for (int i = 0; i < 3; i++) begin
            if (l != 4'd0 && c != key_byte(l)) begin
                l = key_fallback(l);
            end
        end
        if (c == key_byte(l)) begin
            l = l + 4'd1;
        end
        return l;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        logic [7:0] b;
        unique case (c)
            8'h6E:   b = 8'h0A;
            8'h72:   b = 8'h0D;
            8'h74:   b = 8'h09;
            8'h62:   b = 8'h08;
            8'h66:   b = 8'h0C;
            default: b = c;
        endcase
        return b;
    endfunction

    // Returns {is_digit, value}.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else begin
            r = 5'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/json_content_field_unescaper.sv
`timescale 1ns / 1ps
`default_nettype none

// Finds the first "content":" key in a byte stream and returns the JSON string
// body that follows, with escapes decoded and \u code points written as UTF-8.
// One input byte is taken per cycle as long as the word queue between the
// parser and the output stage has room. Each result word leaves the output
// buffer at one word per cycle while out_stall is low; one byte can cause up
// to five words (a surrogate flush, a literal byte and a status word), and
// the queue of FIFO_DEPTH entries absorbs these bursts. The first word of a
// byte passes through the queue and then the output buffer register before
// it appears. Every byte marked end_of_message ends with a status word,
// after which the block searches for the key again.
module json_content_field_unescaper #(
    parameter int FIFO_DEPTH = jcfu_pkg::FIFO_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             is_data,
    output logic [1:0]       status,
    output logic             last
);

    jcfu_pkg::rec_t push_rec, pop_rec;
    logic push, pop, fifo_full, fifo_avail;

    jcfu_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .fifo_full      (fifo_full),
        .push           (push),
        .rec            (push_rec)
    );

    jcfu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .pop_rec   (pop_rec),
        .full      (fifo_full),
        .not_empty (fifo_avail)
    );

    jcfu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (pop_rec),
        .rec_avail (fifo_avail),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .is_data   (is_data),
        .status    (status),
        .last      (last)
    );

endmodule

`default_nettype wire

// File: hw/rtl/jcfu_front.sv
`timescale 1ns / 1ps
`default_nettype none

module jcfu_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [7:0]      in_byte,
    input  wire logic            end_of_message,
    input  wire logic            fifo_full,
    output logic                 push,
    output jcfu_pkg::rec_t       rec
);

    jcfu_pkg::phase_t    phase_reg, phase_next, step_phase;
    jcfu_pkg::hex_mode_t hex_mode_reg, hex_mode_next, feed_mode;
    logic [3:0]  key_len_reg, key_len_next, key_cand;
    logic [1:0]  hex_cnt_reg, hex_cnt_next;
    logic [15:0] hex_val_reg, hex_val_next, feed_val;
    logic        hex_stop_reg, hex_stop_next, feed_stop;
    logic        hex_neg_reg, hex_neg_next, feed_neg;
    logic [9:0]  hi_reg, hi_next, step_hi;
    logic [1:0]  done_st_reg, done_st_next, step_done_st;
    logic        take, feed_full, res_is_hi, is_ws;
    logic [4:0]  dig;
    logic [31:0] hex_res, pair_cp;

    assign in_stall  = fifo_full;
    assign take      = in_valid && !fifo_full;
    assign feed_full = (hex_cnt_reg == 2'd3);
    assign dig       = jcfu_pkg::hex_digit(in_byte);
    assign is_ws     = (in_byte == jcfu_pkg::CH_SPACE) || (in_byte >= 8'h09 && in_byte <= 8'h0D);
    assign key_cand  = jcfu_pkg::kmp_step(key_len_reg, in_byte);

    always_comb
    begin
        feed_mode = hex_mode_reg;
        feed_val  = hex_val_reg;
        feed_stop = hex_stop_reg;
        feed_neg  = hex_neg_reg;
        if (!hex_stop_reg) begin
            if (hex_mode_reg == jcfu_pkg::HM_LEAD && is_ws) begin
                feed_mode = hex_mode_reg;
            end else if (hex_mode_reg == jcfu_pkg::HM_LEAD &&
                         (in_byte == jcfu_pkg::CH_PLUS || in_byte == jcfu_pkg::CH_MINUS)) begin
                feed_neg  = (in_byte == jcfu_pkg::CH_MINUS);
                feed_mode = jcfu_pkg::HM_SIGN;
            end else if ((hex_mode_reg == jcfu_pkg::HM_LEAD || hex_mode_reg == jcfu_pkg::HM_SIGN)
                         && in_byte == jcfu_pkg::CH_ZERO) begin
                feed_mode = jcfu_pkg::HM_ZERO;
            end else if (hex_mode_reg == jcfu_pkg::HM_ZERO &&
                         (in_byte == jcfu_pkg::CH_LX || in_byte == jcfu_pkg::CH_UX)) begin
                feed_mode = jcfu_pkg::HM_X;
            end else if (dig[4]) begin
                feed_val  = {hex_val_reg[11:0], dig[3:0]};
                feed_mode = jcfu_pkg::HM_DIG;
            end else begin
                feed_stop = 1'b1;
            end
        end
    end

    // A minus sign makes the value negative with 32-bit wrap.
    assign hex_res   = feed_neg ? ((~{16'd0, feed_val}) + 32'd1) : {16'd0, feed_val};
    assign res_is_hi = (hex_res >= jcfu_pkg::SUR_HI_MIN) && (hex_res <= jcfu_pkg::SUR_HI_MAX);
    assign pair_cp   = jcfu_pkg::CP_PLANE1 + {12'd0, hi_reg, 10'd0} + hex_res
                       - jcfu_pkg::SUR_LO_MIN;

    always_comb
    begin
        step_phase    = phase_reg;
        step_hi       = hi_reg;
        step_done_st  = done_st_reg;
        key_len_next  = key_len_reg;
        hex_mode_next = hex_mode_reg;
        hex_val_next  = hex_val_reg;
        hex_stop_next = hex_stop_reg;
        hex_neg_next  = hex_neg_reg;
        hex_cnt_next  = hex_cnt_reg;
        if (take) begin
            unique case (phase_reg)
                jcfu_pkg::PH_KEY:
                begin
                    if (in_byte == jcfu_pkg::CH_NUL) begin
                        step_phase   = jcfu_pkg::PH_DONE;
                        step_done_st = jcfu_pkg::ST_NOT_FOUND;
                    end else if (key_cand == jcfu_pkg::KEY_LEN) begin
                        step_phase   = jcfu_pkg::PH_BODY;
                        key_len_next = 4'd0;
                    end else begin
                        key_len_next = key_cand;
                    end
                end
                jcfu_pkg::PH_BODY, jcfu_pkg::PH_SWAIT:
                begin
                    if (phase_reg == jcfu_pkg::PH_SWAIT && in_byte == jcfu_pkg::CH_BSLASH) begin
                        step_phase = jcfu_pkg::PH_SBS;
                    end else if (in_byte == jcfu_pkg::CH_QUOTE) begin
                        step_phase   = jcfu_pkg::PH_DONE;
                        step_done_st = jcfu_pkg::ST_CLOSED;
                    end else if (in_byte == jcfu_pkg::CH_NUL) begin
                        step_phase   = jcfu_pkg::PH_DONE;
                        step_done_st = jcfu_pkg::ST_OPEN;
                    end else if (in_byte == jcfu_pkg::CH_BSLASH) begin
                        step_phase = jcfu_pkg::PH_ESC;
                    end else begin
                        step_phase = jcfu_pkg::PH_BODY;
                    end
                end
                jcfu_pkg::PH_ESC, jcfu_pkg::PH_SBS:
                begin
                    if (in_byte == jcfu_pkg::CH_NUL) begin
                        step_phase   = jcfu_pkg::PH_DONE;
                        step_done_st = jcfu_pkg::ST_OPEN;
                    end else if (in_byte == jcfu_pkg::CH_U) begin
                        step_phase    = (phase_reg == jcfu_pkg::PH_SBS) ? jcfu_pkg::PH_HEX2
                                                                        : jcfu_pkg::PH_HEX1;
                        hex_cnt_next  = 2'd0;
                        hex_val_next  = 16'd0;
                        hex_stop_next = 1'b0;
                        hex_mode_next = jcfu_pkg::HM_LEAD;
                        hex_neg_next  = 1'b0;
                    end else begin
                        step_phase = jcfu_pkg::PH_BODY;
                    end
                end
                jcfu_pkg::PH_HEX1, jcfu_pkg::PH_HEX2:
                begin
                    if (in_byte == jcfu_pkg::CH_NUL) begin
                        step_phase   = jcfu_pkg::PH_DONE;
                        step_done_st = jcfu_pkg::ST_OPEN;
                    end else begin
                        hex_mode_next = feed_mode;
                        hex_val_next  = feed_val;
                        hex_stop_next = feed_stop;
                        hex_neg_next  = feed_neg;
                        hex_cnt_next  = hex_cnt_reg + 2'd1;
                        if (feed_full) begin
                            if (phase_reg == jcfu_pkg::PH_HEX1 && res_is_hi) begin
                                step_phase = jcfu_pkg::PH_SWAIT;
                                step_hi    = hex_res[9:0];
                            end else begin
                                step_phase = jcfu_pkg::PH_BODY;
                            end
                        end
                    end
                end
                jcfu_pkg::PH_DONE:
                begin
                    step_phase = phase_reg;
                end
                default:
                begin
                    step_phase = phase_reg;
                end
            endcase
        end
        phase_next   = step_phase;
        hi_next      = step_hi;
        done_st_next = step_done_st;
        if (take && end_of_message) begin
            phase_next    = jcfu_pkg::PH_KEY;
            key_len_next  = 4'd0;
            hex_cnt_next  = 2'd0;
            hex_val_next  = 16'd0;
            hex_stop_next = 1'b0;
            hex_mode_next = jcfu_pkg::HM_LEAD;
            hex_neg_next  = 1'b0;
            hi_next       = 10'd0;
            done_st_next  = jcfu_pkg::ST_CLOSED;
        end
    end

    always_comb
    begin
        rec = '0;
        unique case (phase_reg)
            jcfu_pkg::PH_BODY, jcfu_pkg::PH_SWAIT:
            begin
                if (phase_reg == jcfu_pkg::PH_SWAIT && in_byte != jcfu_pkg::CH_BSLASH) begin
                    rec.cp_valid = 1'b1;
                    rec.cp       = {16'd0, jcfu_pkg::SUR_HI_TAG, hi_reg};
                end
                if (in_byte != jcfu_pkg::CH_QUOTE && in_byte != jcfu_pkg::CH_NUL &&
                    in_byte != jcfu_pkg::CH_BSLASH) begin
                    rec.lit_valid = 1'b1;
                    rec.lit       = in_byte;
                end
            end
            jcfu_pkg::PH_ESC, jcfu_pkg::PH_SBS:
            begin
                if (phase_reg == jcfu_pkg::PH_SBS && in_byte != jcfu_pkg::CH_U) begin
                    rec.cp_valid = 1'b1;
                    rec.cp       = {16'd0, jcfu_pkg::SUR_HI_TAG, hi_reg};
                end
                if (in_byte != jcfu_pkg::CH_NUL && in_byte != jcfu_pkg::CH_U) begin
                    rec.lit_valid = 1'b1;
                    rec.lit       = jcfu_pkg::esc_map(in_byte);
                end
            end
            jcfu_pkg::PH_HEX1:
            begin
                if (in_byte != jcfu_pkg::CH_NUL && feed_full && !res_is_hi) begin
                    rec.cp_valid = 1'b1;
                    rec.cp       = hex_res;
                end
            end
            jcfu_pkg::PH_HEX2:
            begin
                if (in_byte == jcfu_pkg::CH_NUL) begin
                    rec.cp_valid = 1'b1;
                    rec.cp       = {16'd0, jcfu_pkg::SUR_HI_TAG, hi_reg};
                end else if (feed_full) begin
                    rec.cp_valid = 1'b1;
                    rec.cp       = pair_cp;
                end
            end
            jcfu_pkg::PH_KEY, jcfu_pkg::PH_DONE:
            begin
                rec.cp_valid = 1'b0;
            end
            default:
            begin
                rec.cp_valid = 1'b0;
            end
        endcase
        if (end_of_message) begin
            if (step_phase == jcfu_pkg::PH_SWAIT || step_phase == jcfu_pkg::PH_SBS) begin
                rec.cp_valid = 1'b1;
                rec.cp       = {16'd0, jcfu_pkg::SUR_HI_TAG, step_hi};
            end
            rec.stat_valid = 1'b1;
            if (step_phase == jcfu_pkg::PH_KEY) begin
                rec.stat = jcfu_pkg::ST_NOT_FOUND;
            end else if (step_phase == jcfu_pkg::PH_DONE) begin
                rec.stat = step_done_st;
            end else begin
                rec.stat = jcfu_pkg::ST_OPEN;
            end
        end
    end

    assign push = take && (rec.cp_valid || rec.lit_valid || rec.stat_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg    <= jcfu_pkg::PH_KEY;
            key_len_reg  <= 4'd0;
            hex_cnt_reg  <= 2'd0;
            hex_val_reg  <= 16'd0;
            hex_stop_reg <= 1'b0;
            hex_mode_reg <= jcfu_pkg::HM_LEAD;
            hex_neg_reg  <= 1'b0;
            hi_reg       <= 10'd0;
            done_st_reg  <= jcfu_pkg::ST_CLOSED;
        end else begin
            phase_reg    <= phase_next;
            key_len_reg  <= key_len_next;
            hex_cnt_reg  <= hex_cnt_next;
            hex_val_reg  <= hex_val_next;
            hex_stop_reg <= hex_stop_next;
            hex_mode_reg <= hex_mode_next;
            hex_neg_reg  <= hex_neg_next;
            hi_reg       <= hi_next;
            done_st_reg  <= done_st_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/jcfu_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module jcfu_fifo #(
    parameter int DEPTH = jcfu_pkg::FIFO_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire jcfu_pkg::rec_t  push_rec,
    input  wire logic            pop,
    output jcfu_pkg::rec_t       pop_rec,
    output logic                 full,
    output logic                 not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jcfu_pkg::rec_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_rec   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != CNT_W'(DEPTH)))
        else $error("word written into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != '0))
        else $error("word read from an empty queue");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/jcfu_back.sv
`timescale 1ns / 1ps
`default_nettype none

module jcfu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire jcfu_pkg::rec_t  rec,
    input  wire logic            rec_avail,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           out_byte,
    output logic                 is_data,
    output logic [1:0]           status,
    output logic                 last
);

    localparam int N = jcfu_pkg::MAX_RES;
    localparam int CW = jcfu_pkg::BUF_CNT_W;

    logic [7:0]    buf_byte_reg [N];
    logic [7:0]    buf_byte_next [N];
    logic [N-1:0]  buf_data_reg, buf_data_next;
    logic [1:0]    buf_stat_reg, buf_stat_next;
    logic [CW-1:0] buf_cnt_reg, buf_cnt_next;
    logic [2:0]    ncp;
    logic [7:0]    cpb [4];
    logic [7:0]    enc_byte [N];
    logic [N-1:0]  enc_data;
    logic [CW-1:0] enc_cnt;
    logic          deliver;

    assign out_valid = (buf_cnt_reg != '0);
    assign deliver   = out_valid && !out_stall;
    assign pop       = rec_avail && ((buf_cnt_reg == '0) ||
                                     (buf_cnt_reg == CW'(1) && !out_stall));
    assign out_byte  = buf_byte_reg[0];
    assign is_data   = buf_data_reg[0];
    assign status    = buf_data_reg[0] ? jcfu_pkg::ST_CLOSED : buf_stat_reg;
    assign last      = (buf_cnt_reg == CW'(1));

    always_comb
    begin
        ncp = 3'd0;
        for (int i = 0; i < 4; i++) begin
            cpb[i] = 8'h00;
        end
        if (rec.cp_valid) begin
            if (rec.cp <= jcfu_pkg::CP_1B_MAX) begin
                ncp    = 3'd1;
                cpb[0] = rec.cp[7:0];
            end else if (rec.cp <= jcfu_pkg::CP_2B_MAX) begin
                ncp    = 3'd2;
                cpb[0] = {3'b110, rec.cp[10:6]};
                cpb[1] = {2'b10, rec.cp[5:0]};
            end else if (rec.cp <= jcfu_pkg::CP_3B_MAX) begin
                ncp    = 3'd3;
                cpb[0] = {4'b1110, rec.cp[15:12]};
                cpb[1] = {2'b10, rec.cp[11:6]};
                cpb[2] = {2'b10, rec.cp[5:0]};
            end else if (rec.cp <= jcfu_pkg::CP_MAX) begin
                ncp    = 3'd4;
                cpb[0] = {5'b11110, rec.cp[20:18]};
                cpb[1] = {2'b10, rec.cp[17:12]};
                cpb[2] = {2'b10, rec.cp[11:6]};
                cpb[3] = {2'b10, rec.cp[5:0]};
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++) begin
            enc_byte[i] = 8'h00;
            enc_data[i] = 1'b0;
            if (3'(i) < ncp) begin
                enc_byte[i] = cpb[i % 4];
                enc_data[i] = 1'b1;
            end else if (rec.lit_valid && 3'(i) == ncp) begin
                enc_byte[i] = rec.lit;
                enc_data[i] = 1'b1;
            end
        end
        enc_cnt = CW'(ncp) + CW'(rec.lit_valid) + CW'(rec.stat_valid);
    end

    always_comb
    begin
        buf_byte_next = buf_byte_reg;
        buf_data_next = buf_data_reg;
        buf_stat_next = buf_stat_reg;
        buf_cnt_next  = buf_cnt_reg;
        if (pop) begin
            buf_byte_next = enc_byte;
            buf_data_next = enc_data;
            buf_stat_next = rec.stat;
            buf_cnt_next  = enc_cnt;
        end else if (deliver) begin
            for (int i = 0; i < N - 1; i++) begin
                buf_byte_next[i] = buf_byte_reg[i + 1];
            end
            buf_byte_next[N - 1] = 8'h00;
            buf_data_next        = {1'b0, buf_data_reg[N-1:1]};
            buf_cnt_next         = buf_cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            buf_cnt_reg <= '0;
        end else begin
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_byte_reg <= buf_byte_next;
        buf_data_reg <= buf_data_next;
        buf_stat_reg <= buf_stat_next;
    end

`ifndef ASSERT_OFF
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_data) |-> last)
        else $error("status word is not the last word of its byte");
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        buf_cnt_reg <= CW'(N))
        else $error("result buffer holds more words than one byte can cause");
`endif

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TEXT_BYTES  = 470;
    localparam int HOLD_AFTER  = 120;
    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_WAIT  = 20;

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;

    localparam logic [2:0]  HEX_DIGITS = 3'd4;
    localparam logic [1:0]  DATA_ST    = jcfu_pkg::ST_CLOSED;
    localparam logic [87:0] KEY_TEXT   = "\"content\":\"";

    typedef struct packed {
        logic [7:0] ch;
        logic       eom;
    } stim_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       data;
        logic [1:0] st;
        logic       last;
    } out_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_message = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       is_data;
    logic [1:0] status;
    logic       last;

    stim_t      text_q[$];
    logic [7:0] msg_q[$];
    out_word_t  decoded_q[$];
    out_word_t  byte_words[$];

    jcfu_pkg::phase_t    dec_phase;
    jcfu_pkg::hex_mode_t dec_hex_mode;
    logic [3:0]  dec_key_len;
    logic [2:0]  dec_hex_count;
    logic [15:0] dec_hex_value;
    logic        dec_hex_stop;
    logic        dec_hex_neg;
    logic [15:0] dec_high;
    logic [1:0]  dec_done_st;

    int error_count = 0;
    int cycle_count = 0;
    int message_count = 0;
    int bytes_accepted = 0;
    int words_checked = 0;
    int peak_words = 0;
    int status_count[3] = '{0, 0, 0};
    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    json_content_field_unescaper u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .is_data        (is_data),
        .status         (status),
        .last           (last)
    );

    function automatic logic [7:0] key_char(input int idx);
        return KEY_TEXT[8 * (10 - idx) +: 8];
    endfunction

    function automatic void clear_decoder();
        dec_phase     = jcfu_pkg::PH_KEY;
        dec_hex_mode  = jcfu_pkg::HM_LEAD;
        dec_key_len   = 4'd0;
        dec_hex_count = 3'd0;
        dec_hex_value = 16'h0000;
        dec_hex_stop  = 1'b0;
        dec_hex_neg   = 1'b0;
        dec_high      = 16'h0000;
        dec_done_st   = jcfu_pkg::ST_CLOSED;
    endfunction

    function automatic void add_word(input logic [7:0] ch, input logic data,
                                     input logic [1:0] st);
        out_word_t w;
        w.ch   = ch;
        w.data = data;
        w.st   = st;
        w.last = 1'b0;
        if (byte_words.size() < jcfu_pkg::MAX_RES)
            byte_words.push_back(w);
    endfunction

    function automatic void add_code_point(input logic [31:0] cp);
        if (cp <= jcfu_pkg::CP_1B_MAX) begin
            add_word(cp[7:0], 1'b1, DATA_ST);
        end
        else if (cp <= jcfu_pkg::CP_2B_MAX) begin
            add_word({3'b110, cp[10:6]}, 1'b1, DATA_ST);
            add_word({2'b10, cp[5:0]}, 1'b1, DATA_ST);
        end
        else if (cp <= jcfu_pkg::CP_3B_MAX) begin
            add_word({4'b1110, cp[15:12]}, 1'b1, DATA_ST);
            add_word({2'b10, cp[11:6]}, 1'b1, DATA_ST);
            add_word({2'b10, cp[5:0]}, 1'b1, DATA_ST);
        end
        else if (cp <= jcfu_pkg::CP_MAX) begin
            add_word({5'b11110, cp[20:18]}, 1'b1, DATA_ST);
            add_word({2'b10, cp[17:12]}, 1'b1, DATA_ST);
            add_word({2'b10, cp[11:6]}, 1'b1, DATA_ST);
            add_word({2'b10, cp[5:0]}, 1'b1, DATA_ST);
        end
    endfunction

    function automatic void close_content(input logic [1:0] st);
        dec_phase   = jcfu_pkg::PH_DONE;
        dec_done_st = st;
    endfunction

    function automatic void open_hex(input jcfu_pkg::phase_t next_phase);
        dec_phase     = next_phase;
        dec_hex_mode  = jcfu_pkg::HM_LEAD;
        dec_hex_count = 3'd0;
        dec_hex_value = 16'h0000;
        dec_hex_stop  = 1'b0;
        dec_hex_neg   = 1'b0;
    endfunction

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (c >= "a" && c <= "f")
            d = c - "a" + 8'd10;
        else if (c >= "A" && c <= "F")
            d = c - "A" + 8'd10;
        else
            return 5'd0;
        return {1'b1, d[3:0]};
    endfunction

    // Follows a C strtol prefix over exactly four bytes; returns 1 on the fourth.
    function automatic logic feed_hex(input logic [7:0] c);
        logic [4:0] nib;
        logic       is_space;
        nib = nibble_of(c);
        is_space = (c == jcfu_pkg::CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        if (!dec_hex_stop && !(dec_hex_mode == jcfu_pkg::HM_LEAD && is_space)) begin
            if (dec_hex_mode == jcfu_pkg::HM_LEAD &&
                (c == jcfu_pkg::CH_PLUS || c == jcfu_pkg::CH_MINUS)) begin
                dec_hex_neg  = (c == jcfu_pkg::CH_MINUS);
                dec_hex_mode = jcfu_pkg::HM_SIGN;
            end
            else if ((dec_hex_mode == jcfu_pkg::HM_LEAD || dec_hex_mode == jcfu_pkg::HM_SIGN)
                     && c == jcfu_pkg::CH_ZERO) begin
                dec_hex_mode = jcfu_pkg::HM_ZERO;
            end
            else if (dec_hex_mode == jcfu_pkg::HM_ZERO &&
                     (c == jcfu_pkg::CH_LX || c == jcfu_pkg::CH_UX)) begin
                dec_hex_mode = jcfu_pkg::HM_X;
            end
            else if (nib[4]) begin
                dec_hex_value = {dec_hex_value[11:0], nib[3:0]};
                dec_hex_mode  = jcfu_pkg::HM_DIG;
            end
            else begin
                dec_hex_stop = 1'b1;
            end
        end
        dec_hex_count = dec_hex_count + 3'd1;
        return dec_hex_count >= HEX_DIGITS;
    endfunction

    function automatic logic [31:0] hex_code();
        logic [31:0] v;
        v = {16'h0000, dec_hex_value};
        return dec_hex_neg ? 32'd0 - v : v;
    endfunction

    function automatic void body_char(input logic [7:0] c);
        if (c == jcfu_pkg::CH_QUOTE)
            close_content(jcfu_pkg::ST_CLOSED);
        else if (c == jcfu_pkg::CH_NUL)
            close_content(jcfu_pkg::ST_OPEN);
        else if (c == jcfu_pkg::CH_BSLASH)
            dec_phase = jcfu_pkg::PH_ESC;
        else
            add_word(c, 1'b1, DATA_ST);
    endfunction

    function automatic void escape_char(input logic [7:0] c);
        dec_phase = jcfu_pkg::PH_BODY;
        case (c)
            jcfu_pkg::CH_NUL: close_content(jcfu_pkg::ST_OPEN);
            "n":              add_word(CH_LF, 1'b1, DATA_ST);
            "r":              add_word(CH_CR, 1'b1, DATA_ST);
            "t":              add_word(CH_TAB, 1'b1, DATA_ST);
            "b":              add_word(CH_BS, 1'b1, DATA_ST);
            "f":              add_word(CH_FF, 1'b1, DATA_ST);
            jcfu_pkg::CH_U:   open_hex(jcfu_pkg::PH_HEX1);
            default:          add_word(c, 1'b1, DATA_ST);
        endcase
    endfunction

    function automatic void decode_byte(input logic [7:0] c, input logic eom);
        logic [31:0] cp;
        logic [1:0]  st;
        byte_words.delete();
        case (dec_phase)
            jcfu_pkg::PH_KEY:
            begin
                if (c == jcfu_pkg::CH_NUL) begin
                    close_content(jcfu_pkg::ST_NOT_FOUND);
                end
                else begin
                    if (dec_key_len >= jcfu_pkg::KEY_LEN)
                        dec_key_len = 4'd0;
                    // A partial match of the quoted name ends in a quote that may open the key.
                    while (dec_key_len > 0 && c != key_char(dec_key_len))
                        dec_key_len = (dec_key_len == 4'd9) ? 4'd1 : 4'd0;
                    if (c == key_char(dec_key_len))
                        dec_key_len = dec_key_len + 4'd1;
                    if (dec_key_len >= jcfu_pkg::KEY_LEN)
                        dec_phase = jcfu_pkg::PH_BODY;
                end
            end
            jcfu_pkg::PH_BODY: body_char(c);
            jcfu_pkg::PH_ESC:  escape_char(c);
            jcfu_pkg::PH_HEX1:
            begin
                if (c == jcfu_pkg::CH_NUL) begin
                    close_content(jcfu_pkg::ST_OPEN);
                end
                else if (feed_hex(c)) begin
                    cp = hex_code();
                    if (cp >= jcfu_pkg::SUR_HI_MIN && cp <= jcfu_pkg::SUR_HI_MAX) begin
                        dec_high  = cp[15:0];
                        dec_phase = jcfu_pkg::PH_SWAIT;
                    end
                    else begin
                        add_code_point(cp);
                        dec_phase = jcfu_pkg::PH_BODY;
                    end
                end
            end
            jcfu_pkg::PH_SWAIT:
            begin
                if (c == jcfu_pkg::CH_BSLASH) begin
                    dec_phase = jcfu_pkg::PH_SBS;
                end
                else begin
                    add_code_point({16'h0000, dec_high});
                    dec_phase = jcfu_pkg::PH_BODY;
                    body_char(c);
                end
            end
            jcfu_pkg::PH_SBS:
            begin
                if (c == jcfu_pkg::CH_U) begin
                    open_hex(jcfu_pkg::PH_HEX2);
                end
                else begin
                    add_code_point({16'h0000, dec_high});
                    escape_char(c);
                end
            end
            jcfu_pkg::PH_HEX2:
            begin
                if (c == jcfu_pkg::CH_NUL) begin
                    add_code_point({16'h0000, dec_high});
                    close_content(jcfu_pkg::ST_OPEN);
                end
                else if (feed_hex(c)) begin
                    cp = jcfu_pkg::CP_PLANE1
                         + (({16'h0000, dec_high} - jcfu_pkg::SUR_HI_MIN) << 10)
                         + (hex_code() - jcfu_pkg::SUR_LO_MIN);
                    add_code_point(cp);
                    dec_phase = jcfu_pkg::PH_BODY;
                end
            end
            default: ;
        endcase
        if (eom) begin
            if (dec_phase == jcfu_pkg::PH_SWAIT || dec_phase == jcfu_pkg::PH_SBS)
                add_code_point({16'h0000, dec_high});
            if (dec_phase == jcfu_pkg::PH_KEY)
                st = jcfu_pkg::ST_NOT_FOUND;
            else if (dec_phase == jcfu_pkg::PH_DONE)
                st = dec_done_st;
            else
                st = jcfu_pkg::ST_OPEN;
            add_word(jcfu_pkg::CH_NUL, 1'b0, st);
            clear_decoder();
        end
        if (byte_words.size() > 0)
            byte_words[byte_words.size() - 1].last = 1'b1;
        if (byte_words.size() > peak_words)
            peak_words = byte_words.size();
        foreach (byte_words[i])
            decoded_q.push_back(byte_words[i]);
    endfunction

    function automatic void add_char(input logic [7:0] c);
        msg_q.push_back(c);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_q.push_back(s[i]);
    endfunction

    function automatic void add_key();
        for (int i = 0; i < 11; i++)
            msg_q.push_back(key_char(i));
    endfunction

    function automatic void add_noise(input int count, input logic allow_nul);
        for (int i = 0; i < count; i++)
            msg_q.push_back(allow_nul ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(1, 255)));
    endfunction

    function automatic void add_hex_escape(input logic [15:0] v);
        add_text("\\u");
        if ($urandom_range(0, 1))
            add_text($sformatf("%04x", v));
        else
            add_text($sformatf("%04X", v));
    endfunction

    function automatic void add_hex_digits(input int count);
        string digits;
        digits = "0123456789abcdefABCDEF";
        for (int i = 0; i < count; i++)
            msg_q.push_back(digits[$urandom_range(0, 21)]);
    endfunction

    function automatic logic [15:0] pick_high();
        return jcfu_pkg::SUR_HI_MIN[15:0] + 16'($urandom_range(0, 1023));
    endfunction

    function automatic string odd_hex();
        case ($urandom_range(0, 14))
            0:       return " +1a";
            1:       return "-001";
            2:       return "0x7f";
            3:       return "0X4A";
            4:       return "+0x1";
            5:       return "  -1";
            6:       return "\t0x0";
            7:       return " zz9";
            8:       return "-FFF";
            9:       return "00x1";
            10:      return "x123";
            11:      return "0x-1";
            12:      return "+-12";
            13:      return "\v\f\r9";
            default: return "\n 7g";
        endcase
    endfunction

    function automatic void add_fragment();
        logic [7:0] c;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:
            begin
                c = 8'($urandom_range(32, 126));
                add_char((c == jcfu_pkg::CH_QUOTE || c == jcfu_pkg::CH_BSLASH) ? "_" : c);
            end
            6: add_char(8'($urandom_range(128, 255)));
            7:
            begin
                c = 8'($urandom_range(1, 255));
                add_char((c == jcfu_pkg::CH_QUOTE || c == jcfu_pkg::CH_BSLASH) ? "~" : c);
            end
            8:
            begin
                add_char(jcfu_pkg::CH_BSLASH);
                case ($urandom_range(0, 7))
                    0: add_char("n");
                    1: add_char("r");
                    2: add_char("t");
                    3: add_char("b");
                    4: add_char("f");
                    5: add_char(jcfu_pkg::CH_QUOTE);
                    6: add_char(jcfu_pkg::CH_BSLASH);
                    default: add_char("/");
                endcase
            end
            9:
            begin
                add_char(jcfu_pkg::CH_BSLASH);
                add_char(8'($urandom_range(1, 255)));
            end
            10: add_hex_escape(16'($urandom_range(0, 16'h7F)));
            11: add_hex_escape(16'($urandom_range(16'h80, 16'h7FF)));
            12:
            begin
                add_hex_escape(16'($urandom_range(0, 16'hFFFF)));
            end
            13, 14:
            begin
                add_hex_escape(pick_high());
                add_hex_escape(jcfu_pkg::SUR_LO_MIN[15:0] + 16'($urandom_range(0, 1023)));
            end
            15:
            begin
                add_hex_escape(pick_high());
                if ($urandom_range(0, 1)) begin
                    add_hex_escape(16'($urandom_range(0, 16'hFFFF)));
                end
                else begin
                    add_text("\\u");
                    add_text(odd_hex());
                end
            end
            16:
            begin
                add_hex_escape(pick_high());
                if ($urandom_range(0, 1))
                    add_char(8'($urandom_range(32, 126)));
                else
                    add_text($urandom_range(0, 1) ? "\\n" : "\\\\");
            end
            17:
            begin
                add_text("\\u");
                add_text(odd_hex());
            end
            18:
            begin
                add_text("\\u");
                add_noise(4, 1'b0);
            end
            default:
            begin
                add_hex_escape(pick_high());
                add_char(jcfu_pkg::CH_BSLASH);
                c = 8'($urandom_range(1, 255));
                add_char((c == jcfu_pkg::CH_U) ? "x" : c);
            end
        endcase
    endfunction

    function automatic void add_ending();
        logic [7:0] c;
        case ($urandom_range(0, 12))
            0, 1, 2, 3, 4:
            begin
                add_char(jcfu_pkg::CH_QUOTE);
                add_noise($urandom_range(0, 3), 1'b1);
                if ($urandom_range(0, 5) == 0)
                    add_key();
            end
            5:
            begin
                add_char(jcfu_pkg::CH_NUL);
                add_noise($urandom_range(0, 3), 1'b1);
            end
            6: ;
            7:
            begin
                add_char(jcfu_pkg::CH_BSLASH);
                if ($urandom_range(0, 1))
                    add_char(jcfu_pkg::CH_NUL);
            end
            8:
            begin
                add_text("\\u");
                add_hex_digits($urandom_range(0, 3));
                if ($urandom_range(0, 1)) begin
                    add_char(jcfu_pkg::CH_NUL);
                    add_noise($urandom_range(0, 2), 1'b1);
                end
            end
            9: add_hex_escape(pick_high());
            10:
            begin
                add_hex_escape(pick_high());
                add_char(jcfu_pkg::CH_BSLASH);
            end
            11:
            begin
                add_hex_escape(pick_high());
                add_char(jcfu_pkg::CH_BSLASH);
                c = 8'($urandom_range(1, 255));
                add_char((c == jcfu_pkg::CH_U) ? "n" : c);
            end
            default:
            begin
                add_hex_escape(pick_high());
                add_text("\\u");
                add_hex_digits($urandom_range(0, 3));
                if ($urandom_range(0, 1))
                    add_char(jcfu_pkg::CH_NUL);
            end
        endcase
    endfunction

    function automatic void send_message();
        stim_t item;
        foreach (msg_q[i]) begin
            item.ch  = msg_q[i];
            item.eom = (i == msg_q.size() - 1);
            text_q.push_back(item);
        end
        msg_q.delete();
        message_count++;
    endfunction

    function automatic void build_message();
        int kind;
        kind = $urandom_range(0, 9);
        add_noise($urandom_range(0, 3), 1'b0);
        if (kind <= 7) begin
            if ($urandom_range(0, 3) == 0)
                add_text("\"cont");
            if ($urandom_range(0, 4) == 0)
                add_text("\"content\"");
            add_key();
            repeat ($urandom_range(0, 6))
                add_fragment();
            add_ending();
        end
        else if (kind == 8) begin
            add_noise($urandom_range(1, 8), 1'b0);
            if ($urandom_range(0, 1))
                add_text("\"content\":");
        end
        else begin
            add_char(jcfu_pkg::CH_NUL);
            add_noise($urandom_range(0, 3), 1'b1);
            if ($urandom_range(0, 1))
                add_key();
        end
        send_message();
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    always #10 clk = ~clk;

    always @(posedge clk or negedge rst_n) begin : drive_proc
        stim_t item;
        if (!rst_n) begin
            in_valid       <= 1'b0;
            in_byte        <= 8'h00;
            end_of_message <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall) begin
                decode_byte(in_byte, end_of_message);
                bytes_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (text_q.size() > 0) begin
                    item = text_q.pop_front();
                    in_valid       <= 1'b1;
                    in_byte        <= item.ch;
                    end_of_message <= item.eom;
                    if (send_calm > 0) begin
                        send_calm--;
                    end
                    else begin
                        send_gap = pick_idle();
                        if ($urandom_range(0, 49) == 0)
                            send_calm = 60;
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin : check_proc
        out_word_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (decoded_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected word %h/%b/%0d/%b with nothing pending",
                             $time, out_byte, is_data, status, last);
                end
                else begin
                    want = decoded_q.pop_front();
                    if (out_byte !== want.ch || is_data !== want.data ||
                        status !== want.st || last !== want.last) begin
                        error_count++;
                        $display("%0t: byte/data/status/last expected %h/%b/%0d/%b got %h/%b/%0d/%b",
                                 $time, want.ch, want.data, want.st, want.last,
                                 out_byte, is_data, status, last);
                    end
                end
                if (is_data === 1'b0 && status < 2'd3)
                    status_count[status]++;
                words_checked++;
            end
            // One long hold-off lets the input side fill up and stall.
            if (!hold_done && words_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (recv_stall > 0) begin
                recv_stall--;
                out_stall <= 1'b1;
            end
            else if (recv_calm > 0) begin
                recv_calm--;
                out_stall <= 1'b0;
            end
            else begin
                recv_stall = ($urandom_range(0, 2) == 0) ? pick_idle() : 0;
                out_stall <= (recv_stall > 0);
                if (recv_stall > 0)
                    recv_stall--;
                if ($urandom_range(0, 49) == 0)
                    recv_calm = 60;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words pending",
                     cycle_count, decoded_q.size());
            $display("json_content_field_unescaper test failed");
            $finish;
        end
    end

    initial begin
        clear_decoder();
        // A zero byte before any key means the key is not found.
        add_char(jcfu_pkg::CH_NUL);
        send_message();
        // The highest code point as a surrogate pair, then the closing quote.
        add_key();
        add_text("\\uDBFF\\uDFFF\"");
        send_message();
        while (text_q.size() < TEXT_BYTES)
            build_message();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (text_q.size() > 0 || in_valid)
            @(posedge clk);
        while (decoded_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d bytes in %0d messages; checked %0d words, up to %0d from one byte.",
                 bytes_accepted, message_count, words_checked, peak_words);
        $display("Status words: %0d closed, %0d key not found, %0d ended inside content.",
                 status_count[0], status_count[1], status_count[2]);
        if (error_count == 0)
            $display("json_content_field_unescaper test passed");
        else
            $display("json_content_field_unescaper test failed");
        $finish;
    end

endmodule
